// ----- rtl/asp_pkg.sv -----
// Shared types and constants of the servo angle command parser.
package asp_pkg;

    localparam int unsigned ANGLE_W  = 8;
    localparam int unsigned PULSE_W  = 16;
    localparam int unsigned VALUE_W  = 10;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [7:0] RX_CR    = 8'h0D;
    localparam logic [7:0] ASCII_0  = 8'h30;
    localparam logic [7:0] ASCII_9  = 8'h39;

    localparam logic [ANGLE_W-1:0] ANGLE_LIMIT = 8'd180;

    localparam logic [PULSE_W-1:0] PULSE_ZERO_RST = 16'd500;
    localparam logic [PULSE_W-1:0] PULSE_FULL_RST = 16'd2500;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_AT_ZERO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_AT_FULL = 2'd1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // ceil(2^32 / 180); exact floor division for products below 2^24
    localparam int unsigned     RECIP_W    = 25;
    localparam int unsigned     RECIP_SH   = 32;
    localparam logic [RECIP_W-1:0] RECIP_180 = 25'd23860930;

    localparam int unsigned PROD_W = ANGLE_W + PULSE_W;

    typedef struct packed {
        logic               err;
        logic [ANGLE_W-1:0] angle;
    } t_cmd;

    typedef struct packed {
        logic               status;
        logic [ANGLE_W-1:0] angle;
        logic [PULSE_W-1:0] pulse;
    } t_result;

endpackage

// ----- rtl/asp_fifo.sv -----
// Small register queue with occupancy count.
module asp_fifo #(
    parameter int unsigned WIDTH  = 9,
    parameter int unsigned ADDR_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  logic [WIDTH-1:0]  i_data,
    input  logic              i_rd,
    output logic [WIDTH-1:0]  o_data,
    output logic              o_empty,
    output logic [ADDR_W:0]   o_count
);
    localparam int unsigned DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [ADDR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [ADDR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [ADDR_W:0]   r_count, n_count;
    logic              w_do_wr;
    logic              w_do_rd;

    assign w_do_wr = i_wr && (r_count != (ADDR_W+1)'(DEPTH));
    assign w_do_rd = i_rd && (r_count != '0);

    always_comb begin
        n_wr_ptr = w_do_wr ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_do_rd ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_do_wr && !w_do_rd) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_wr && w_do_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

// ----- rtl/asp_parser.sv -----
// Front end: frames received bytes and classifies each frame end.
module asp_parser #(
    parameter int unsigned MAX_DIGITS = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_rx_byte,
    output logic                o_cmd_valid,
    output asp_pkg::t_cmd       o_cmd
);
    import asp_pkg::*;

    logic               r_in_frame, n_in_frame;
    logic [1:0]         r_digit_count, n_digit_count;
    logic [VALUE_W-1:0] r_value, n_value;
    logic               w_is_digit;
    logic [3:0]         w_digit;
    logic [VALUE_W+3:0] w_scaled;

    assign w_is_digit = (i_rx_byte >= ASCII_0) && (i_rx_byte <= ASCII_9);
    assign w_digit    = 4'(i_rx_byte - ASCII_0);
    assign w_scaled   = ((VALUE_W+4)'(r_value) << 3) + ((VALUE_W+4)'(r_value) << 1)
                      + (VALUE_W+4)'(w_digit);

    always_comb begin
        n_in_frame    = r_in_frame;
        n_digit_count = r_digit_count;
        n_value       = r_value;
        o_cmd_valid   = 1'b0;
        o_cmd.err     = STATUS_OK;
        o_cmd.angle   = '0;
        if (i_valid) begin
            if (!r_in_frame) begin
                // open a frame on a digit, drop anything else
                if (w_is_digit) begin
                    n_in_frame    = 1'b1;
                    n_digit_count = 2'd1;
                    n_value       = VALUE_W'(w_digit);
                end
            end else if (i_rx_byte == RX_CR) begin
                o_cmd_valid   = 1'b1;
                o_cmd.angle   = (r_value > VALUE_W'(ANGLE_LIMIT)) ? ANGLE_LIMIT
                                                                  : ANGLE_W'(r_value);
                n_in_frame    = 1'b0;
                n_digit_count = '0;
                n_value       = '0;
            end else if (w_is_digit && (r_digit_count < 2'(MAX_DIGITS))) begin
                n_value       = VALUE_W'(w_scaled);
                n_digit_count = r_digit_count + 2'd1;
            end else begin
                o_cmd_valid   = 1'b1;
                o_cmd.err     = STATUS_BAD;
                n_in_frame    = 1'b0;
                n_digit_count = '0;
                n_value       = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame    <= 1'b0;
            r_digit_count <= '0;
            r_value       <= '0;
        end else begin
            r_in_frame    <= n_in_frame;
            r_digit_count <= n_digit_count;
            r_value       <= n_value;
        end
    end

endmodule

// ----- rtl/asp_mapper.sv -----
// Back end: maps angles onto pulse widths in a two stage pipeline.
module asp_mapper #(
    parameter int unsigned OUT_ADDR_W = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [15:0]            i_pulse_at_zero,
    input  logic [15:0]            i_pulse_at_full,
    input  logic                   i_cmd_avail,
    input  asp_pkg::t_cmd          i_cmd,
    output logic                   o_cmd_take,
    input  logic [OUT_ADDR_W:0]    i_out_count,
    output logic                   o_res_valid,
    output asp_pkg::t_result       o_res
);
    import asp_pkg::*;

    localparam int unsigned OUT_DEPTH = 1 << OUT_ADDR_W;

    logic [PULSE_W:0]   w_diff;
    logic [PULSE_W-1:0] r_abs_diff;
    logic               r_neg;

    logic               r_v1;
    t_cmd               r_cmd1;
    logic [PROD_W-1:0]  r_m1;

    logic               r_v2;
    t_cmd               r_cmd2;
    logic [PULSE_W-1:0] r_q2;

    logic [OUT_ADDR_W+1:0]          w_used;
    logic [PROD_W+RECIP_W-1:0]      w_recip_prod;
    logic [PULSE_W-1:0]             w_signed_q;

    // user changes config only while idle, unchecked; so the slope is settled
    assign w_diff = {1'b0, i_pulse_at_full} - {1'b0, i_pulse_at_zero};

    always_ff @(posedge i_clk) begin
        r_neg      <= w_diff[PULSE_W];
        r_abs_diff <= w_diff[PULSE_W] ? PULSE_W'(-w_diff) : w_diff[PULSE_W-1:0];
    end

    // issue only when every result in flight has a slot reserved
    assign w_used = (OUT_ADDR_W+2)'(i_out_count) + (OUT_ADDR_W+2)'(r_v1)
                  + (OUT_ADDR_W+2)'(r_v2);
    assign o_cmd_take = i_cmd_avail && (w_used < (OUT_ADDR_W+2)'(OUT_DEPTH));

    assign w_recip_prod = (PROD_W+RECIP_W)'(r_m1) * (PROD_W+RECIP_W)'(RECIP_180);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= o_cmd_take;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd1 <= i_cmd;
        r_m1   <= PROD_W'(i_cmd.angle * r_abs_diff);
        r_cmd2 <= r_cmd1;
        r_q2   <= w_recip_prod[RECIP_SH +: PULSE_W];
    end

    assign w_signed_q = r_neg ? PULSE_W'(-r_q2) : r_q2;

    always_comb begin
        o_res_valid = r_v2;
        o_res.status = r_cmd2.err;
        if (r_cmd2.err == STATUS_BAD) begin
            o_res.angle = '0;
            o_res.pulse = '0;
        end else begin
            o_res.angle = r_cmd2.angle;
            o_res.pulse = i_pulse_at_zero + w_signed_q;
        end
    end

endmodule

// ----- rtl/ascii_angle_to_servo_pulse.sv -----
// Top level of the ASCII servo angle command parser.
//
// Received bytes enter on the push/full queue port, one transfer per cycle
// whenever full is low. A decimal digit opens a frame, up to MAX_DIGITS
// digits build the angle, carriage return closes it. Each closed or dropped
// frame yields one result on the empty/pop queue port: status 0 with the
// clamped angle and the mapped pulse width, or status 1 with zeros when a
// bad byte or an extra digit drops the frame. Bytes that cause no result
// leave nothing behind.
//
// Throughput is one byte per cycle while full is low. After the transfer of
// the closing byte the parser writes the command queue; once the output
// queue has room reserved, the angle times slope multiply, the reciprocal
// multiply for the divide by 180 and the output queue write follow in that
// order, each through its own register, and the result can then be popped.
//
// Reset clears the frame state, both queues and the pipeline, and loads the
// pulse registers with 500 and 2500. When the receiver holds off pop, the
// output queue fills, the mapper stops issuing, the command queue fills and
// full rises; no result is ever dropped. Write pulse registers only while
// the block is idle.
module ascii_angle_to_servo_pulse #(
    parameter int unsigned MAX_DIGITS = 3,
    parameter int unsigned CMD_ADDR_W = 1,
    parameter int unsigned OUT_ADDR_W = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [7:0]                 i_rx_byte,
    output logic                       empty,
    input  logic                       pop,
    output logic                       o_status,
    output logic [asp_pkg::ANGLE_W-1:0] o_angle_degrees,
    output logic [asp_pkg::PULSE_W-1:0] o_pulse_width,
    input  logic                       i_cfg_we,
    input  logic [asp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [asp_pkg::PULSE_W-1:0] i_cfg_data
);
    import asp_pkg::*;

    logic [PULSE_W-1:0] r_pulse_at_zero;
    logic [PULSE_W-1:0] r_pulse_at_full;

    logic               w_accept;
    logic               w_cmd_push;
    t_cmd               w_cmd_in;
    t_cmd               w_cmd_out;
    logic               w_cmd_empty;
    logic [CMD_ADDR_W:0] w_cmd_count;
    logic               w_cmd_take;
    logic               w_res_valid;
    t_result            w_res_in;
    t_result            w_res_out;
    logic [OUT_ADDR_W:0] w_out_count;

    // hold the pulse registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_at_zero <= PULSE_ZERO_RST;
            r_pulse_at_full <= PULSE_FULL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PULSE_AT_ZERO: r_pulse_at_zero <= i_cfg_data;
                CFG_PULSE_AT_FULL: r_pulse_at_full <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // full is conservative: any byte may close a frame
    assign full     = (w_cmd_count == (CMD_ADDR_W+1)'(1 << CMD_ADDR_W));
    assign w_accept = push && !full;

    asp_parser #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_rx_byte   (i_rx_byte),
        .o_cmd_valid (w_cmd_push),
        .o_cmd       (w_cmd_in)
    );

    asp_fifo #(
        .WIDTH  ($bits(t_cmd)),
        .ADDR_W (CMD_ADDR_W)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_cmd_push),
        .i_data  (w_cmd_in),
        .i_rd    (w_cmd_take),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty),
        .o_count (w_cmd_count)
    );

    asp_mapper #(
        .OUT_ADDR_W (OUT_ADDR_W)
    ) u_mapper (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pulse_at_zero (r_pulse_at_zero),
        .i_pulse_at_full (r_pulse_at_full),
        .i_cmd_avail     (!w_cmd_empty),
        .i_cmd           (w_cmd_out),
        .o_cmd_take      (w_cmd_take),
        .i_out_count     (w_out_count),
        .o_res_valid     (w_res_valid),
        .o_res           (w_res_in)
    );

    asp_fifo #(
        .WIDTH  ($bits(t_result)),
        .ADDR_W (OUT_ADDR_W)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_valid),
        .i_data  (w_res_in),
        .i_rd    (pop),
        .o_data  (w_res_out),
        .o_empty (empty),
        .o_count (w_out_count)
    );

    assign o_status        = w_res_out.status;
    assign o_angle_degrees = w_res_out.angle;
    assign o_pulse_width   = w_res_out.pulse;

endmodule
